[design/bfa_pkg.sv]
package bfa_pkg;

	// Bitmap geometry
	localparam int WORD_BITS   = 64;
	localparam int MAX_BITS    = 4096;
	localparam int STORE_WORDS = MAX_BITS / WORD_BITS;
	localparam int WORD_AW     = $clog2(STORE_WORDS);
	localparam int POS_W       = $clog2(WORD_BITS);
	localparam int IDX_W       = WORD_AW + POS_W;
	localparam int NWORDS_W    = WORD_AW + 1;

	// Port field widths
	localparam int CMD_W = 2;
	localparam int CFG_W = 13;

	localparam logic [CFG_W-1:0] BITS_IN_USE_RST = CFG_W'(MAX_BITS);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET  = 2'd0,
		CMD_CLR  = 2'd1,
		CMD_FIND = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR,
		ST_SCAN,
		ST_POST
	} state_t;

	// Position of the lowest zero bit of a word (0 when the word is full)
	function automatic logic [POS_W-1:0] first_zero(input word_t w);
		logic [POS_W-1:0] pos;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				pos = POS_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

[design/bfa_req_if.sv]
interface bfa_req_if
	import bfa_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [IDX_W-1:0] bit_index;

	modport source(output valid, output cmd, output bit_index, input ready);
	modport sink(input valid, input cmd, input bit_index, output ready);
endinterface

[design/bfa_rsp_if.sv]
interface bfa_rsp_if
	import bfa_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] free_index;
	logic             found;

	modport source(output valid, output free_index, output found, input ready);
	modport sink(input valid, input free_index, input found, output ready);
endinterface

[design/bfa_ram.sv]
module bfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/bfa_ctrl.sv]
module bfa_ctrl
	import bfa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [NWORDS_W-1:0] nwords,
	bfa_req_if.sink             req,
	bfa_rsp_if.source           rsp,
	output logic                ram_we,
	output logic [WORD_AW-1:0]  ram_waddr,
	output word_t               ram_wdata,
	output logic [WORD_AW-1:0]  ram_raddr,
	input  word_t               ram_rdata
);

	state_t state_q, state_d;

	logic               is_set_q;
	logic [POS_W-1:0]   pos_q;
	logic [WORD_AW-1:0] scan_addr_q;
	logic [WORD_AW-1:0] chk_addr_q;
	logic [STORE_WORDS-1:0] vld_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic               res_found_q;
	logic               rsp_valid_q;
	logic [IDX_W-1:0]   rsp_idx_q;
	logic               rsp_found_q;

	logic  accept;
	logic  in_range;
	logic  slot_free;
	logic  word_full;
	logic  last_word;
	word_t word_val;

	// Handshake and range checks, and datapath checks on the word that came back from the RAM
	assign accept    = req.valid && req.ready;
	assign in_range  = NWORDS_W'(req.bit_index[IDX_W-1:POS_W]) < nwords;
	assign word_val  = vld_q[chk_addr_q] ? ram_rdata : '0;
	assign word_full = &word_val;
	assign last_word = (NWORDS_W'(chk_addr_q) + NWORDS_W'(1)) == nwords;
	assign slot_free = !rsp_valid_q || rsp.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_SET, CMD_CLR: state_d = in_range ? ST_WR : ST_IDLE;
						CMD_FIND:         state_d = (nwords == '0) ? ST_POST : ST_SCAN;
						default:          state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR:   state_d = ST_IDLE;
			ST_SCAN: begin
				if (!word_full || last_word) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs: handshake and RAM control
	always_comb begin
		req.ready = 1'b0;
		ram_raddr = chk_addr_q;
		ram_we    = 1'b0;
		ram_waddr = chk_addr_q;
		ram_wdata = is_set_q ? (word_val | (word_t'(1) << pos_q))
		                     : (word_val & ~(word_t'(1) << pos_q));
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				ram_raddr = (req.cmd == CMD_FIND) ? '0 : req.bit_index[IDX_W-1:POS_W];
			end
			ST_WR:   ram_we = 1'b1;
			ST_SCAN: ram_raddr = scan_addr_q;
			ST_POST: ram_raddr = chk_addr_q;
			default: ram_raddr = chk_addr_q;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_POST && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Command latch, scan pointer and result
	always_ff @(posedge clk) begin
		chk_addr_q <= ram_raddr;
		if (accept) begin
			is_set_q    <= (req.cmd == CMD_SET);
			pos_q       <= req.bit_index[POS_W-1:0];
			scan_addr_q <= WORD_AW'(1);
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			scan_addr_q <= scan_addr_q + WORD_AW'(1);
			if (!word_full) begin
				res_idx_q   <= {chk_addr_q, first_zero(word_val)};
				res_found_q <= 1'b1;
			end
		end
		if (state_q == ST_POST && slot_free) begin
			rsp_idx_q   <= res_idx_q;
			rsp_found_q <= res_found_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.free_index = rsp_idx_q;
	assign rsp.found      = rsp_found_q;

endmodule

[design/bitmap_first_free_allocator_top.sv]
// Bitmap allocator of 4096 bits held as 64 words of 64 bits in a RAM; every bit
// reads zero after reset. One command per beat on req: set bit, clear bit, or
// find the lowest zero bit. Set and clear read the word, then write it back,
// and give no response; an index beyond the words in use is dropped. Find
// walks the words in use one per cycle through the single RAM read port and
// returns one response beat on rsp; when the bitmap is full, found is 0 and
// free_index is 0. The block takes one command at a time; a finished response
// waits in an output register and the next command is taken meanwhile.
// cfg_wdata sets bits_in_use (sizes above 4096 count as 4096, rounded down to
// whole words) and may be written only while no command is in flight.
module bitmap_first_free_allocator_top
	import bfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	bfa_req_if.sink          req,
	bfa_rsp_if.source        rsp
);

	logic [CFG_W-1:0]    bits_in_use_q;
	logic [NWORDS_W-1:0] nwords;

	logic               ram_we;
	logic [WORD_AW-1:0] ram_waddr;
	word_t              ram_wdata;
	logic [WORD_AW-1:0] ram_raddr;
	word_t              ram_rdata;

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= BITS_IN_USE_RST;
		end else if (cfg_we) begin
			bits_in_use_q <= cfg_wdata;
		end
	end

	// Words in use, clipped to the store
	assign nwords = (bits_in_use_q > CFG_W'(MAX_BITS)) ? NWORDS_W'(STORE_WORDS)
	                                                    : NWORDS_W'(bits_in_use_q >> POS_W);

	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.nwords    (nwords),
		.req       (req),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (STORE_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[tb/tb_bitmap_first_free_allocator_top.sv]
module tb_bitmap_first_free_allocator_top;
	import bfa_pkg::*;

	// no-op command code, ignored by the block
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	localparam int SETTLE_CYCLES = 80;    // longest find plus margin
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int STALL_LIMIT   = 3000;  // cycles without any beat
	localparam int PHASE_ITEMS   = 130;
	localparam int MAX_PRINTS    = 40;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
	} req_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0] free_index;
		logic             found;
	} alloc_rsp_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	bfa_req_if req_bus();
	bfa_rsp_if rsp_bus();

	bitmap_first_free_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	always #6 clk = ~clk;

	// shadow bitmap and size register
	logic [WORD_BITS-1:0] shadow_map [STORE_WORDS];
	logic [CFG_W-1:0]     shadow_size = BITS_IN_USE_RST;

	req_beat_t  cmd_q[$];      // commands waiting to be driven
	alloc_rsp_t free_slot_q[$]; // expected find answers, oldest first

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit send_pause = 1'b0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	bit req_took = 1'b0;
	int quiet_cycles = 0;

	initial begin
		for (int w = 0; w < STORE_WORDS; w++) begin
			shadow_map[w] = '0;
		end
	end

	task automatic report_mismatch(input string msg);
		if (errors < MAX_PRINTS) begin
			$display("mismatch: %s", msg);
		end
		errors++;
	endtask

	// limit in use in bits: size clipped to capacity, whole words only
	function automatic int unsigned bits_limit(input logic [CFG_W-1:0] size);
		int unsigned s;
		s = (size > MAX_BITS) ? MAX_BITS : size;
		return (s / WORD_BITS) * WORD_BITS;
	endfunction

	// apply one accepted command to the shadow bitmap
	task automatic track_command(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx);
		int unsigned lim;
		alloc_rsp_t  ans;
		int          w;
		int          b;
		lim = bits_limit(shadow_size);
		case (c)
			CMD_SET: begin
				if (idx < lim) shadow_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
			end
			CMD_CLR: begin
				if (idx < lim) shadow_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
			end
			CMD_FIND: begin
				ans = '0;
				for (w = 0; w < lim / WORD_BITS && !ans.found; w++) begin
					for (b = 0; b < WORD_BITS && !ans.found; b++) begin
						if (!shadow_map[w][b]) begin
							ans.found      = 1'b1;
							ans.free_index = IDX_W'(w * WORD_BITS + b);
						end
					end
				end
				free_slot_q.push_back(ans);
			end
			default: ;
		endcase
	endtask

	// input side: register writes and accepted command beats
	always @(posedge clk) begin
		if (arst_n) begin
			req_took <= req_bus.valid && req_bus.ready;
			if (cfg_we) shadow_size = cfg_wdata;
			if (req_bus.valid && req_bus.ready) track_command(req_bus.cmd, req_bus.bit_index);
		end else begin
			req_took <= 1'b0;
		end
	end

	// command driver
	always @(negedge clk) begin
		req_beat_t nxt;
		if (arst_n && (!req_bus.valid || req_took)) begin
			if (cmd_q.size() != 0 && !send_pause &&
			    ($urandom_range(99) >= send_idle_pct)) begin
				nxt = cmd_q.pop_front();
				req_bus.valid     <= 1'b1;
				req_bus.cmd       <= nxt.cmd;
				req_bus.bit_index <= nxt.idx;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// response ready: random stalls, plus a long hold on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_bus.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_token != hold_seen) begin
			rsp_bus.ready <= 1'b0;
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
		end else begin
			rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// response checker
	always @(posedge clk) begin
		alloc_rsp_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (free_slot_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat free_index %0d found %0b",
					rsp_bus.free_index, rsp_bus.found));
			end else begin
				want = free_slot_q.pop_front();
				if (rsp_bus.found !== want.found)
					report_mismatch($sformatf("found %0b, want %0b",
						rsp_bus.found, want.found));
				if (rsp_bus.free_index !== want.free_index)
					report_mismatch($sformatf("free_index %0d, want %0d",
						rsp_bus.free_index, want.free_index));
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic push_cmd(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx);
		req_beat_t it;
		it.cmd = c;
		it.idx = idx;
		cmd_q.push_back(it);
	endtask

	// all commands taken, all answers back, then let the block settle
	task automatic wait_drained();
		while (cmd_q.size() != 0 || req_bus.valid || free_slot_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] sizes [8];
		int          ph;
		int          n;
		int          r;
		int          lim;
		int          win;
		int          wspan;
		int          start;
		int          len;
		logic [CMD_W-1:0] c;
		logic [IDX_W-1:0] idx;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req_bus.valid     = 1'b0;
		req_bus.cmd       = CMD_SET;
		req_bus.bit_index = '0;
		rsp_bus.ready     = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset size, ends of the index range, no-op command
		push_cmd(CMD_FIND, 12'd0);
		push_cmd(CMD_SET, 12'd0);
		push_cmd(CMD_FIND, 12'hFFF);
		push_cmd(CMD_SET, 12'hFFF);
		push_cmd(CMD_CLR, 12'd0);
		push_cmd(CMD_FIND, 12'd0);
		push_cmd(CMD_NONE, 12'hFFF);
		push_cmd(CMD_SET, 12'd2048);
		push_cmd(CMD_CLR, 12'hFFF);
		push_cmd(CMD_FIND, 12'd5);
		wait_drained();

		// size below one word: nothing in use
		write_size(13'd0);
		push_cmd(CMD_FIND, 12'd0);
		push_cmd(CMD_SET, 12'd0);
		push_cmd(CMD_FIND, 12'd0);
		wait_drained();

		// size above capacity
		write_size(13'h1FFF);
		push_cmd(CMD_FIND, 12'd0);
		push_cmd(CMD_SET, 12'd0);
		push_cmd(CMD_FIND, 12'd0);
		wait_drained();

		// size not a multiple of the word, index past the limit
		write_size(13'd100);
		push_cmd(CMD_SET, 12'd64);
		push_cmd(CMD_SET, 12'd99);
		push_cmd(CMD_SET, 12'd63);
		push_cmd(CMD_FIND, 12'd0);
		push_cmd(CMD_CLR, 12'd0);
		push_cmd(CMD_FIND, 12'd0);
		wait_drained();

		// random phases
		sizes[0] = 13'd64;
		sizes[1] = 13'd128;
		sizes[2] = 13'h1FFF;
		sizes[3] = 13'd192;
		sizes[4] = 13'd256;
		sizes[5] = 13'd4096;
		sizes[6] = 13'd320;
		sizes[7] = CFG_W'($urandom_range(8191));
		for (ph = 0; ph < 8; ph++) begin
			write_size(sizes[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			if (ph == 4) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			lim   = bits_limit(sizes[ph]);
			win   = (lim == 0) ? WORD_BITS : ((lim > 512) ? 512 : lim);
			wspan = (lim / WORD_BITS > 8) ? 8 : ((lim < WORD_BITS) ? 1 : lim / WORD_BITS);
			n = 0;
			while (n < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 20) begin
					// fill run of consecutive bits, occasionally probed
					start = $urandom_range(wspan - 1) * WORD_BITS;
					len   = $urandom_range(16, (win > 128) ? 128 : win);
					for (int k = 0; k < len && n < PHASE_ITEMS; k++) begin
						idx = IDX_W'(start + k);
						push_cmd(CMD_SET, idx);
						n++;
						if ($urandom_range(15) == 0) begin
							push_cmd(CMD_FIND, IDX_W'($urandom));
							n++;
						end
					end
					push_cmd(CMD_FIND, IDX_W'($urandom));
					n++;
				end else if (r < 50) begin
					push_cmd(CMD_FIND, IDX_W'($urandom));
					n++;
				end else if (r < 72) begin
					push_cmd(CMD_CLR, IDX_W'($urandom_range(win - 1)));
					n++;
				end else if (r < 88) begin
					push_cmd(CMD_SET, IDX_W'($urandom_range(win - 1)));
					n++;
				end else begin
					// noise: any command, any index
					c   = CMD_W'($urandom_range(3));
					idx = IDX_W'($urandom);
					push_cmd(c, idx);
					n++;
				end
			end
			if (ph == 4) begin
				// receiver holds off while commands keep coming
				hold_token++;
				while (cmd_q.size() > 40 && cmd_q.size() != 0) @(posedge clk);
				// sender waits until every answer is back
				send_pause = 1'b1;
				while (free_slot_q.size() != 0) @(posedge clk);
				send_pause = 1'b0;
			end
			wait_drained();
		end

		if (free_slot_q.size() != 0)
			report_mismatch($sformatf("%0d answers never came", free_slot_q.size()));
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
